// ===== src/cascaded_motor_current_controller_core_macros.svh =====
// Assertion macros shared by the controller modules.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef CASCADED_MOTOR_CURRENT_CONTROLLER_CORE_MACROS_SVH
`define CASCADED_MOTOR_CURRENT_CONTROLLER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define CMCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("controller check failed");
`define CMCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("controller check failed");
`else
`define CMCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CMCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/cmcc_pkg.sv =====
// Types, widths, limits and the clamp function of the motor current controller.
// Depends on nothing.
package cmcc_pkg;

    localparam int POS_W     = 32;
    localparam int SPD_W     = 16;
    localparam int CUR_W     = 13;
    localparam int TGT_W     = 20;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int ERR_W     = POS_W + 1;
    localparam int DERR_W    = ERR_W + 1;
    localparam int WIDE_W    = 38;
    localparam int VERR_W    = SPD_W + 1;
    localparam int STEP_W    = CUR_W + 1;

    // The PD gains over the common divisor are 1 and 8, the speed gain is 2.
    localparam int PD_D_SHIFT = 3;
    localparam int VEL_SHIFT  = 1;

    localparam logic signed [CUR_W-1:0] CUR_LIMIT  = 13'sd2048;
    localparam logic signed [CUR_W-1:0] VEL_LIMIT  = 13'sd4000;
    localparam logic signed [CUR_W-1:0] SLEW_LIMIT = 13'sd2048;
    localparam logic signed [TGT_W-1:0] POS_LIMIT  = 20'sd500000;

    typedef enum logic [MODE_W-1:0] {
        MODE_CURRENT  = 2'd0,
        MODE_VELOCITY = 2'd1,
        MODE_POSITION = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 2'd0,
        REG_TARGET = 2'd1
    } t_reg_idx;

    typedef struct packed {
        t_mode                     mode;
        logic signed [TGT_W-1:0]   target;
    } t_cfg;

    typedef struct packed {
        logic                      valid;
        logic signed [CUR_W-1:0]   value;
    } t_demand;

    function automatic logic signed [CUR_W-1:0] clamp_sym(
        input logic signed [WIDE_W-1:0] v,
        input logic signed [CUR_W-1:0]  lim
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(lim);
        lo = -hi;
        if (v > hi) begin
            return lim;
        end else if (v < lo) begin
            return -lim;
        end
        return CUR_W'(v);
    endfunction

endpackage

// ===== src/cmcc_ifs.sv =====
// Handshake interfaces for the sample, result and configuration channels.
// Depends on cmcc_pkg.
interface cmcc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cmcc_pkg::POS_W-1:0]     position;
    logic signed [cmcc_pkg::SPD_W-1:0]     speed;
    modport source (output valid, position, speed, input ready);
    modport sink (input valid, position, speed, output ready);
endinterface

interface cmcc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cmcc_pkg::CUR_W-1:0]     current;
    modport source (output valid, current, input ready);
    modport sink (input valid, current, output ready);
endinterface

interface cmcc_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [cmcc_pkg::CFG_IDX_W-1:0]        index;
    logic [cmcc_pkg::TGT_W-1:0]            data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/cmcc_cfg.sv =====
// Configuration register file holding the control mode and the target.
// Depends on cmcc_pkg and cmcc_cfg_if.
module cmcc_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cmcc_cfg_if.sink          i_cfg,
    output cmcc_pkg::t_cfg    o_cfg
);

    cmcc_pkg::t_mode                        r_mode;
    logic signed [cmcc_pkg::TGT_W-1:0]      r_target;
    logic                                   w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= cmcc_pkg::MODE_CURRENT;
            r_target <= '0;
        end else if (w_wr) begin
            unique case (i_cfg.index)
                cmcc_pkg::REG_MODE: begin
                    r_mode <= cmcc_pkg::t_mode'(i_cfg.data[cmcc_pkg::MODE_W-1:0]);
                end
                cmcc_pkg::REG_TARGET: begin
                    r_target <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.mode   = r_mode;
    assign o_cfg.target = r_target;

endmodule

// ===== src/cmcc_demand.sv =====
// Sample register, position PD step and speed step giving the desired current.
// Depends on cmcc_pkg, cmcc_in_if and the assertion macros.
`include "cascaded_motor_current_controller_core_macros.svh"

module cmcc_demand (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cmcc_in_if.sink              i_in,
    input  cmcc_pkg::t_cfg       i_cfg,
    output cmcc_pkg::t_demand    o_demand,
    input  logic                 i_demand_ready
);

    logic                                    r_in_valid;
    logic signed [cmcc_pkg::ERR_W-1:0]       r_err;
    logic signed [cmcc_pkg::SPD_W-1:0]       r_spd;
    logic signed [cmcc_pkg::ERR_W-1:0]       r_last_err;
    logic                                    r_demand_valid;
    logic signed [cmcc_pkg::CUR_W-1:0]       r_want;

    logic signed [cmcc_pkg::TGT_W-1:0]       w_pdes;
    logic signed [cmcc_pkg::ERR_W-1:0]       n_err;
    logic signed [cmcc_pkg::DERR_W-1:0]      w_derr;
    logic signed [cmcc_pkg::WIDE_W-1:0]      w_pd;
    logic signed [cmcc_pkg::CUR_W-1:0]       w_vdes;
    logic signed [cmcc_pkg::VERR_W-1:0]      w_verr;
    logic signed [cmcc_pkg::WIDE_W-1:0]      w_vcmd;
    logic signed [cmcc_pkg::CUR_W-1:0]       n_want;
    logic                                    w_pos_mode;
    logic                                    w_adv;
    logic                                    w_accept;

    // Position error is formed as the sample enters, since the target is static.
    always_comb begin
        if (i_cfg.target > cmcc_pkg::POS_LIMIT) begin
            w_pdes = cmcc_pkg::POS_LIMIT;
        end else if (i_cfg.target < -cmcc_pkg::POS_LIMIT) begin
            w_pdes = -cmcc_pkg::POS_LIMIT;
        end else begin
            w_pdes = i_cfg.target;
        end
        n_err = cmcc_pkg::ERR_W'(w_pdes) - cmcc_pkg::ERR_W'(i_in.position);
    end

    assign w_adv       = r_in_valid && (!r_demand_valid || i_demand_ready);
    assign i_in.ready  = !r_in_valid || w_adv;
    assign w_accept    = i_in.valid && i_in.ready;

    always_comb begin
        w_derr = cmcc_pkg::DERR_W'(r_err) - cmcc_pkg::DERR_W'(r_last_err);
        w_pd   = cmcc_pkg::WIDE_W'(r_err)
               + (cmcc_pkg::WIDE_W'(w_derr) <<< cmcc_pkg::PD_D_SHIFT);
        w_pos_mode = 1'b0;
        unique case (i_cfg.mode)
            cmcc_pkg::MODE_CURRENT: begin
                w_vdes = cmcc_pkg::clamp_sym(cmcc_pkg::WIDE_W'(i_cfg.target),
                                             cmcc_pkg::VEL_LIMIT);
            end
            cmcc_pkg::MODE_VELOCITY: begin
                w_vdes = cmcc_pkg::clamp_sym(cmcc_pkg::WIDE_W'(i_cfg.target),
                                             cmcc_pkg::VEL_LIMIT);
            end
            default: begin
                w_pos_mode = 1'b1;
                w_vdes     = cmcc_pkg::clamp_sym(w_pd, cmcc_pkg::VEL_LIMIT);
            end
        endcase
        w_verr = cmcc_pkg::VERR_W'(w_vdes) - cmcc_pkg::VERR_W'(r_spd);
        w_vcmd = cmcc_pkg::WIDE_W'(w_verr) <<< cmcc_pkg::VEL_SHIFT;
        if (i_cfg.mode == cmcc_pkg::MODE_CURRENT) begin
            n_want = cmcc_pkg::clamp_sym(cmcc_pkg::WIDE_W'(i_cfg.target),
                                         cmcc_pkg::CUR_LIMIT);
        end else begin
            n_want = cmcc_pkg::clamp_sym(w_vcmd, cmcc_pkg::CUR_LIMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_demand_valid <= 1'b0;
            r_last_err     <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (!r_demand_valid || i_demand_ready) begin
                r_demand_valid <= r_in_valid;
            end
            if (w_adv && w_pos_mode) begin
                r_last_err <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err <= n_err;
            r_spd <= i_in.speed;
        end
        if (w_adv) begin
            r_want <= n_want;
        end
    end

    assign o_demand.valid = r_demand_valid;
    assign o_demand.value = r_want;

    `CMCC_ASSERT_IMPL(a_want_range, i_clk, i_rst_n, r_demand_valid,
        r_want <= cmcc_pkg::CUR_LIMIT && r_want >= -cmcc_pkg::CUR_LIMIT)
    `CMCC_ASSERT_NEXT(a_err_hold, i_clk, i_rst_n,
        w_adv && (i_cfg.mode == cmcc_pkg::MODE_CURRENT || i_cfg.mode == cmcc_pkg::MODE_VELOCITY),
        $stable(r_last_err))

endmodule

// ===== src/cmcc_slew.sv =====
// Slew limiter and result register; the result register is also the last current.
// Depends on cmcc_pkg, cmcc_out_if and the assertion macros.
`include "cascaded_motor_current_controller_core_macros.svh"

module cmcc_slew (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cmcc_pkg::t_demand    i_demand,
    output logic                 o_demand_ready,
    cmcc_out_if.source           o_out
);

    logic                                    r_out_valid;
    logic signed [cmcc_pkg::CUR_W-1:0]       r_current;
    logic signed [cmcc_pkg::STEP_W-1:0]      w_diff;
    logic signed [cmcc_pkg::CUR_W-1:0]       w_step;
    logic signed [cmcc_pkg::STEP_W-1:0]      w_sum;
    logic signed [cmcc_pkg::CUR_W-1:0]       n_current;
    logic                                    w_load;

    assign o_demand_ready = !r_out_valid || o_out.ready;
    assign w_load         = i_demand.valid && o_demand_ready;

    always_comb begin
        w_diff    = cmcc_pkg::STEP_W'(i_demand.value) - cmcc_pkg::STEP_W'(r_current);
        w_step    = cmcc_pkg::clamp_sym(cmcc_pkg::WIDE_W'(w_diff), cmcc_pkg::SLEW_LIMIT);
        w_sum     = cmcc_pkg::STEP_W'(r_current) + cmcc_pkg::STEP_W'(w_step);
        n_current = w_sum[cmcc_pkg::CUR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_current   <= '0;
        end else begin
            if (o_demand_ready) begin
                r_out_valid <= i_demand.valid;
            end
            if (w_load) begin
                r_current <= n_current;
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.current = r_current;

    `CMCC_ASSERT_IMPL(a_out_range, i_clk, i_rst_n, r_out_valid,
        r_current <= cmcc_pkg::CUR_LIMIT && r_current >= -cmcc_pkg::CUR_LIMIT)
    `CMCC_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_load, r_out_valid)

endmodule

// ===== src/cascaded_motor_current_controller_core.sv =====
// Cascaded position, velocity and current controller producing one current command
// per feedback item. A new item can be accepted in every clock cycle while the result
// channel is not stalled; an item passes through the sample register, where the
// position error is formed, then the desired-current register after the PD and speed
// steps, and is then held in the result register after the slew limiter. The stored
// position error and the last current each close their feedback loop within one stage,
// which sets the rate at one item per cycle. Configuration is written through its own
// channel, which is always ready, and must only be written while the block is idle.
// Depends on cmcc_pkg, the channel interfaces, cmcc_cfg, cmcc_demand and cmcc_slew.
module cascaded_motor_current_controller_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cmcc_cfg_if.sink      i_cfg,
    cmcc_in_if.sink       i_in,
    cmcc_out_if.source    o_out
);

    cmcc_pkg::t_cfg       w_cfg;
    cmcc_pkg::t_demand    w_demand;
    logic                 w_demand_ready;

    cmcc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    cmcc_demand u_demand (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_cfg          (w_cfg),
        .o_demand       (w_demand),
        .i_demand_ready (w_demand_ready)
    );

    cmcc_slew u_slew (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_demand       (w_demand),
        .o_demand_ready (w_demand_ready),
        .o_out          (o_out)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the cascaded motor current controller core.
// It predicts every current command from the feedback items and the register writes.
// Depends on cmcc_pkg, the channel interfaces and the controller RTL.
module tb_top;

    localparam logic [cmcc_pkg::MODE_W-1:0]    MODE_SPARE   = 2'd3;
    localparam logic [cmcc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [cmcc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam longint PD_KP         = 128;
    localparam longint PD_KD         = 1024;
    localparam longint VEL_KP        = 256;
    localparam longint GAIN_DIV      = 128;
    localparam int RANDOM_ITEMS      = 1500;
    localparam int SETTLE_CYCLES     = 6;
    localparam int DRAIN_LIMIT       = 2000;
    localparam int CYCLE_LIMIT       = 400000;

    logic clk;
    logic rst_n;

    cmcc_in_if  in_ch ();
    cmcc_out_if out_ch ();
    cmcc_cfg_if cfg_ch ();

    cascaded_motor_current_controller_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [cmcc_pkg::MODE_W-1:0]       pred_mode;
    logic signed [cmcc_pkg::TGT_W-1:0] pred_target;
    longint                            pred_last_err;
    longint                            pred_last_cur;
    logic signed [cmcc_pkg::CUR_W-1:0] current_q[$];
    int                                fails;
    int                                cycles;
    bit                                steady;

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint clip(input longint v, input longint lim);
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // The previous position error is only updated in position control; the unused
    // mode value behaves as position control.
    function automatic logic signed [cmcc_pkg::CUR_W-1:0] predict_current(
        input logic signed [cmcc_pkg::POS_W-1:0] pos,
        input logic signed [cmcc_pkg::SPD_W-1:0] spd
    );
        longint want;
        longint vdes;
        longint err;
        longint derr;
        if (pred_mode == cmcc_pkg::MODE_CURRENT) begin
            want = clip(longint'(pred_target), longint'(cmcc_pkg::CUR_LIMIT));
        end else begin
            if (pred_mode == cmcc_pkg::MODE_VELOCITY) begin
                vdes = clip(longint'(pred_target), longint'(cmcc_pkg::VEL_LIMIT));
            end else begin
                err = clip(longint'(pred_target), longint'(cmcc_pkg::POS_LIMIT))
                    - longint'(pos);
                derr = err - pred_last_err;
                pred_last_err = err;
                vdes = clip((PD_KP * err + PD_KD * derr) / GAIN_DIV,
                            longint'(cmcc_pkg::VEL_LIMIT));
            end
            want = clip((VEL_KP * (vdes - longint'(spd))) / GAIN_DIV,
                        longint'(cmcc_pkg::CUR_LIMIT));
        end
        pred_last_cur = pred_last_cur
                      + clip(want - pred_last_cur, longint'(cmcc_pkg::SLEW_LIMIT));
        return cmcc_pkg::CUR_W'(pred_last_cur);
    endfunction

    task automatic report_mismatch(input string what, input int expv, input int gotv);
        fails++;
        $display("mismatch at cycle %0d: %s, expected %0d, got %0d",
                 cycles, what, expv, gotv);
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == cmcc_pkg::REG_MODE) begin
                    pred_mode = cfg_ch.data[cmcc_pkg::MODE_W-1:0];
                end else if (cfg_ch.index == cmcc_pkg::REG_TARGET) begin
                    pred_target = cfg_ch.data;
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                current_q.push_back(predict_current(in_ch.position, in_ch.speed));
            end
            if (out_ch.valid && out_ch.ready) begin
                if (current_q.size() == 0) begin
                    report_mismatch("current with no item pending", 0, out_ch.current);
                end else if (out_ch.current !== current_q[0]) begin
                    report_mismatch("current", current_q[0], out_ch.current);
                    void'(current_q.pop_front());
                end else begin
                    void'(current_q.pop_front());
                end
            end
        end
    end

    function automatic int draw_gap();
        if (steady || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    always begin : result_sink
        int gap;
        @(negedge clk);
        if (rst_n) begin
            gap = draw_gap();
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    task automatic send_sample(
        input logic signed [cmcc_pkg::POS_W-1:0] pos,
        input logic signed [cmcc_pkg::SPD_W-1:0] spd
    );
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.position = pos;
        in_ch.speed    = spd;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge clk);
    endtask

    // Holds the sender until every pending current command has been checked.
    task automatic settle();
        in_ch.valid = 1'b0;
        while (current_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Registers are only written once every item in flight has left the block.
    task automatic write_reg(
        input logic [cmcc_pkg::CFG_IDX_W-1:0] idx,
        input logic [cmcc_pkg::TGT_W-1:0]     val
    );
        settle();
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_mode(input logic [cmcc_pkg::MODE_W-1:0] m);
        logic [cmcc_pkg::TGT_W-1:0] val;
        val = cmcc_pkg::TGT_W'($urandom);
        val[cmcc_pkg::MODE_W-1:0] = m;
        write_reg(cmcc_pkg::REG_MODE, val);
    endtask

    task automatic set_target(input int t);
        write_reg(cmcc_pkg::REG_TARGET, cmcc_pkg::TGT_W'(t));
    endtask

    task automatic test_reset_defaults();
        send_sample(32'sh7fffffff, 16'sh7fff);
        send_sample(32'sh80000000, 16'sh8000);
    endtask

    task automatic test_current_control();
        settle();
        set_mode(cmcc_pkg::MODE_CURRENT);
        set_target(2048);
        send_sample(32'sh12345678, 16'sh7fff);
        set_target(-2048);
        send_sample(32'sh80000000, 16'sh8000);
        send_sample(32'sh7fffffff, 16'sh0000);
        set_target(524287);
        send_sample(32'sh00000000, 16'sh1234);
        send_sample(32'shffffffff, 16'shffff);
        set_target(-524288);
        send_sample(32'sh55555555, 16'sh5555);
        send_sample(32'shaaaaaaaa, 16'shaaaa);
    endtask

    task automatic test_velocity_control();
        settle();
        set_mode(cmcc_pkg::MODE_VELOCITY);
        set_target(4000);
        send_sample(32'sh00000000, 16'sh8000);
        send_sample(32'sh7fffffff, 16'sh7fff);
        set_target(-524288);
        send_sample(32'sh80000000, 16'sh0000);
        set_target(1000);
        send_sample(32'sh00000000, 16'sd995);
        send_sample(32'sh00000000, -16'sd3);
    endtask

    task automatic test_position_control();
        settle();
        set_mode(cmcc_pkg::MODE_POSITION);
        set_target(524287);
        send_sample(32'sh80000000, 16'sh0000);
        send_sample(32'sh7fffffff, 16'sh7fff);
        set_target(100);
        send_sample(32'sd100, 16'sd0);
        send_sample(32'sd99, 16'sd1);
        settle();
        set_mode(MODE_SPARE);
        set_target(-524288);
        send_sample(32'sd0, 16'sh8000);
        send_sample(-32'sd499990, 16'sd20);
    endtask

    task automatic test_error_hold();
        settle();
        set_mode(cmcc_pkg::MODE_POSITION);
        set_target(0);
        send_sample(-32'sd5, 16'sd0);
        settle();
        set_mode(cmcc_pkg::MODE_VELOCITY);
        send_sample(32'sh7fffffff, 16'sd7);
        settle();
        set_mode(cmcc_pkg::MODE_CURRENT);
        send_sample(32'sh80000000, 16'sd7);
        settle();
        set_mode(cmcc_pkg::MODE_POSITION);
        send_sample(-32'sd5, 16'sd0);
    endtask

    task automatic test_spare_registers();
        settle();
        write_reg(REG_SPARE_LO, cmcc_pkg::TGT_W'($urandom));
        write_reg(REG_SPARE_HI, cmcc_pkg::TGT_W'($urandom));
        send_sample(-32'sd3, 16'sd2);
        send_sample(32'sd4, -16'sd2);
    endtask

    function automatic int draw_target();
        int extremes[9] = '{-524288, 524287, -500000, 500000, -4000, 4000, -2048, 2048, 0};
        unique case ($urandom_range(0, 3))
            0: return extremes[$urandom_range(0, 8)];
            1: return int'($urandom_range(0, 8000)) - 4000;
            2: return int'($urandom_range(0, 1000000)) - 500000;
            default: return int'(cmcc_pkg::TGT_W'($urandom))
                          - (int'($urandom_range(0, 1)) << cmcc_pkg::TGT_W);
        endcase
    endfunction

    // Most items sit close to the position set point, so that in position control the PD
    // step works unsaturated; the rest span the whole field range.
    task automatic test_random_phases();
        int sent;
        int count;
        int tgt;
        int pos_ref;
        logic [cmcc_pkg::MODE_W-1:0] m;
        logic signed [cmcc_pkg::POS_W-1:0] pos;
        logic signed [cmcc_pkg::SPD_W-1:0] spd;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            m = cmcc_pkg::MODE_W'($urandom_range(0, 3));
            tgt = draw_target();
            set_mode(m);
            set_target(tgt);
            if ($urandom_range(0, 7) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          cmcc_pkg::TGT_W'($urandom));
            end
            steady = ($urandom_range(0, 4) == 0);
            pos_ref = int'(clip(longint'(tgt), longint'(cmcc_pkg::POS_LIMIT)));
            count = $urandom_range(10, 80);
            repeat (count) begin
                if ($urandom_range(0, 3) != 0) begin
                    pos = cmcc_pkg::POS_W'(pos_ref + int'($urandom_range(0, 400)) - 200);
                    spd = cmcc_pkg::SPD_W'(int'($urandom_range(0, 8000)) - 4000);
                end else begin
                    pos = cmcc_pkg::POS_W'($urandom);
                    spd = cmcc_pkg::SPD_W'($urandom);
                end
                send_sample(pos, spd);
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    initial begin : run_tests
        int waited;
        fails          = 0;
        steady         = 1'b0;
        pred_mode      = cmcc_pkg::MODE_CURRENT;
        pred_target    = '0;
        pred_last_err  = 0;
        pred_last_cur  = 0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.position = '0;
        in_ch.speed    = '0;
        out_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = cmcc_pkg::REG_MODE;
        cfg_ch.data    = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_current_control();
        test_velocity_control();
        test_position_control();
        test_error_hold();
        test_spare_registers();
        test_random_phases();

        in_ch.valid = 1'b0;
        waited = 0;
        while (current_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        if (current_q.size() != 0) begin
            report_mismatch("current commands never delivered", 0, current_q.size());
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fails == 0) begin
            $display("** cascaded_motor_current_controller_core: PASSED **");
        end else begin
            $display("** cascaded_motor_current_controller_core: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("** cascaded_motor_current_controller_core: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/cmcc_pkg.sv
src/cmcc_ifs.sv
src/cmcc_cfg.sv
src/cmcc_demand.sv
src/cmcc_slew.sv
src/cascaded_motor_current_controller_core.sv
dv/tb_top.sv
